@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the allocation table manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FCTM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FCTM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The expression must hold at every clock edge outside reset.
`define FCTM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`endif

@@ hdl/fctm_pkg.sv @@
// Types, codes and constants shared by the allocation table manager modules.
package fctm_pkg;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int CLUSTER_W = 16;
  localparam int WIDE_W = CLUSTER_W + 1;
  localparam int CIU_W = 12;

  localparam logic [CIU_W-1:0] CIU_RESET = 12'd4094;

  localparam logic [15:0] FREE_ENTRY = 16'h0000;
  localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [15:0] CHAIN_LIMIT = 16'hFFF8;
  localparam logic [15:0] FIRST_DATA = 16'd2;

  localparam logic [2:0] KIND_READ = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_ALLOC = 3'd2;
  localparam logic [2:0] KIND_FREE = 3'd3;
  localparam logic [2:0] KIND_COUNT = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] cluster;
    logic [15:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [15:0] answer;
    logic [1:0]  status;
  } rsp_t;

  typedef enum logic [2:0] {
    RES_ZERO  = 3'd0,
    RES_RDATA = 3'd1,
    RES_INDEX = 3'd2,
    RES_COUNT = 3'd3,
    RES_FREED = 3'd4
  } res_sel_t;

  typedef struct packed {
    logic       clr_step;
    logic       load_req;
    logic       rd_entry;
    logic       wr_entry;
    logic       scan_step;
    logic       alloc_mark;
    logic       chain_rd;
    logic       chain_wr;
    logic       set_res;
    res_sel_t   res_sel;
    logic [1:0] res_status;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [2:0] kind;
    logic       cl_in_range;
    logic       scan_more;
    logic       chk_valid;
    logic       chk_free;
    logic       walk_go;
    logic       walk_range;
  } dp_sts_t;

endpackage

@@ hdl/fctm_controller.sv @@
// Sequencing state machine of the allocation table manager.
module fctm_controller import fctm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    out_stall,
  output logic    out_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [7:0] {
    S_CLEAR     = 8'b0000_0001,
    S_IDLE      = 8'b0000_0010,
    S_DISPATCH  = 8'b0000_0100,
    S_RD_WAIT   = 8'b0000_1000,
    S_SCAN      = 8'b0001_0000,
    S_CHAIN_CHK = 8'b0010_0000,
    S_CHAIN_WR  = 8'b0100_0000,
    S_EMIT      = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_sel = RES_ZERO;
    cmd.res_status = ST_OK;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_EMIT;
        cmd.set_res = 1'b1;
        unique case (sts.kind) inside
          KIND_READ: begin
            if (sts.cl_in_range) begin
              cmd.rd_entry = 1'b1;
              cmd.set_res = 1'b0;
              state_next = S_RD_WAIT;
            end else begin
              cmd.res_status = ST_RANGE;
            end
          end
          KIND_WRITE: begin
            if (sts.cl_in_range) begin
              cmd.wr_entry = 1'b1;
            end else begin
              cmd.res_status = ST_RANGE;
            end
          end
          KIND_ALLOC, KIND_COUNT: begin
            cmd.set_res = 1'b0;
            state_next = S_SCAN;
          end
          KIND_FREE: begin
            cmd.set_res = 1'b0;
            state_next = S_CHAIN_CHK;
          end
          default: begin
            cmd.res_status = ST_RANGE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.set_res = 1'b1;
        cmd.res_sel = RES_RDATA;
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (sts.kind == KIND_ALLOC) begin
          if (sts.chk_valid && sts.chk_free) begin
            cmd.alloc_mark = 1'b1;
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_INDEX;
            state_next = S_EMIT;
          end else if (!sts.scan_more && !sts.chk_valid) begin
            cmd.set_res = 1'b1;
            cmd.res_status = ST_FULL;
            state_next = S_EMIT;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end else begin
          if (!sts.scan_more && !sts.chk_valid) begin
            cmd.set_res = 1'b1;
            cmd.res_sel = RES_COUNT;
            state_next = S_EMIT;
          end else begin
            cmd.scan_step = 1'b1;
          end
        end
      end
      S_CHAIN_CHK: begin
        if (!sts.walk_go) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_FREED;
          state_next = S_EMIT;
        end else if (sts.walk_range) begin
          cmd.set_res = 1'b1;
          cmd.res_sel = RES_FREED;
          cmd.res_status = ST_RANGE;
          state_next = S_EMIT;
        end else begin
          cmd.chain_rd = 1'b1;
          state_next = S_CHAIN_WR;
        end
      end
      S_CHAIN_WR: begin
        // Read data of the current link is ready: clear it and follow it.
        cmd.chain_wr = 1'b1;
        state_next = S_CHAIN_CHK;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/fctm_datapath.sv @@
// Table memory, scan and chain counters, configuration and result registers.
module fctm_datapath import fctm_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  req_t             in_data,
  input  logic             cfg_we,
  input  logic [CIU_W-1:0] cfg_data,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output rsp_t             out_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [WIDE_W-1:0] TABLE_W = WIDE_W'(TABLE_ENTRIES);
  localparam logic [CW-1:0] TABLE_C = CW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_A = AW'(TABLE_ENTRIES - 1);

  logic [15:0] mem [TABLE_ENTRIES];
  logic [15:0] rdata;

  req_t             req;
  logic [CIU_W-1:0] clusters_in_use;
  logic [AW-1:0]    clr_cnt;
  logic [CW-1:0]    rd_idx;
  logic             chk_valid;
  logic [AW-1:0]    chk_idx;
  logic [CW-1:0]    free_cnt;
  logic [15:0]      walk;
  logic [CW-1:0]    walk_cnt;
  rsp_t             res;

  logic [WIDE_W-1:0] end_raw;
  logic [WIDE_W-1:0] scan_end;
  logic              scan_more;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [15:0]       wdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [15:0]       res_answer;

  // The searched range ends at 2 + clusters_in_use, clipped to the table depth.
  assign end_raw = WIDE_W'(clusters_in_use) + WIDE_W'(FIRST_DATA);
  assign scan_end = (end_raw > TABLE_W) ? TABLE_W : end_raw;
  assign scan_more = WIDE_W'(rd_idx) < scan_end;

  assign sts.clr_last = (clr_cnt == LAST_A);
  assign sts.kind = req.kind;
  assign sts.cl_in_range = WIDE_W'(req.cluster) < TABLE_W;
  assign sts.scan_more = scan_more;
  assign sts.chk_valid = chk_valid;
  assign sts.chk_free = (rdata == FREE_ENTRY);
  assign sts.walk_go = (walk >= FIRST_DATA) && (walk < CHAIN_LIMIT);
  assign sts.walk_range = (WIDE_W'(walk) >= TABLE_W) || (walk_cnt == TABLE_C);

  always_comb begin
    we = 1'b0;
    waddr = clr_cnt;
    wdata = FREE_ENTRY;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.wr_entry) begin
      we = 1'b1;
      waddr = req.cluster[AW-1:0];
      wdata = req.entry_value;
    end else if (cmd.alloc_mark) begin
      we = 1'b1;
      waddr = chk_idx;
      wdata = END_OF_CHAIN;
    end else if (cmd.chain_wr) begin
      we = 1'b1;
      waddr = walk[AW-1:0];
    end
  end

  always_comb begin
    re = 1'b0;
    raddr = req.cluster[AW-1:0];
    if (cmd.rd_entry) begin
      re = 1'b1;
    end else if (cmd.scan_step && scan_more) begin
      re = 1'b1;
      raddr = rd_idx[AW-1:0];
    end else if (cmd.chain_rd) begin
      re = 1'b1;
      raddr = walk[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd.res_sel)
      RES_RDATA: res_answer = rdata;
      RES_INDEX: res_answer = 16'(chk_idx);
      RES_COUNT: res_answer = 16'(free_cnt);
      RES_FREED: res_answer = 16'(walk_cnt);
      default:   res_answer = FREE_ENTRY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clusters_in_use <= CIU_RESET;
      clr_cnt <= '0;
      chk_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        clusters_in_use <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (cmd.load_req) begin
        chk_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_valid <= scan_more;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_data;
      rd_idx <= CW'(FIRST_DATA);
      free_cnt <= '0;
      walk <= in_data.cluster;
      walk_cnt <= '0;
    end
    if (cmd.scan_step) begin
      // One read issued and the previous one checked in each cycle.
      if (scan_more) begin
        rd_idx <= rd_idx + CW'(1);
      end
      chk_idx <= rd_idx[AW-1:0];
      if (chk_valid && (rdata == FREE_ENTRY)) begin
        free_cnt <= free_cnt + CW'(1);
      end
    end
    if (cmd.chain_wr) begin
      walk <= rdata;
      walk_cnt <= walk_cnt + CW'(1);
    end
    if (cmd.set_res) begin
      res.answer <= res_answer;
      res.status <= cmd.res_status;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

endmodule

@@ hdl/fat_cluster_table_manager_unit.sv @@
// FAT16 allocation table manager: top level joining controller and datapath.
//
// Requests arrive on in_valid/in_stall/in_data and are taken at an edge with
// in_valid high and in_stall low. Each request gives exactly one result on
// out_valid/out_stall/out_data, in request order. clusters_in_use is written
// through cfg_valid/cfg_ready/cfg_data; cfg_ready is always high.
// An allocate stops at the first free entry and reports full when none is
// found; a count reads the whole searched range. Scans make one table read
// per cycle, pipelined over the single read port. A free chain does a read
// and a write per link.
// One request is worked on at a time; the next is taken once the result has
// moved into the output register, even while that result is still stalled.
// A stalled result holds its value until out_stall falls.
// After rst the table is swept to zero one entry per cycle, with in_stall
// high; configuration writes are taken throughout.
// The register clusters_in_use resets to 4094.
`include "assert_macros.svh"

module fat_cluster_table_manager_unit import fctm_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CIU_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  fctm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fctm_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  `FCTM_ASSERT_SAME(a_no_request_in_clear, cmd.clr_step, in_stall, "request taken during clear")
  `FCTM_ASSERT_ALWAYS(a_one_writer, ($onehot0({cmd.clr_step, cmd.wr_entry, cmd.alloc_mark, cmd.chain_wr})), "several table writers")
  `FCTM_ASSERT_NEXT(a_one_at_a_time, (in_valid && !in_stall), in_stall, "second request taken at once")
  `FCTM_ASSERT_SAME(a_out_slot_free, cmd.out_load, (!out_valid || !out_stall), "result overwritten")

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the FAT16 allocation table manager.
module tb_top import fctm_pkg::*; ();

  localparam int QUIET_LIMIT = 50000;

  // Keeps a private copy of the allocation table and predicts each result.
  class fat_ledger;
    logic [15:0] fat [TABLE_ENTRIES_DEF];
    int unsigned span;
    rsp_t pending [$];

    function new();
      foreach (fat[i]) fat[i] = FREE_ENTRY;
      span = CIU_RESET;
    endfunction

    function void set_span(logic [CIU_W-1:0] v);
      span = v;
    endfunction

    function int unsigned scan_end();
      return (span + 2 > TABLE_ENTRIES_DEF) ? TABLE_ENTRIES_DEF : span + 2;
    endfunction

    function void note_request(req_t r);
      rsp_t want;
      int unsigned c;
      int unsigned nxt;
      int unsigned freed;
      want.answer = '0;
      want.status = ST_OK;
      case (r.kind)
        KIND_READ: begin
          if (r.cluster < TABLE_ENTRIES_DEF) want.answer = fat[r.cluster];
          else want.status = ST_RANGE;
        end
        KIND_WRITE: begin
          if (r.cluster < TABLE_ENTRIES_DEF) fat[r.cluster] = r.entry_value;
          else want.status = ST_RANGE;
        end
        KIND_ALLOC: begin
          want.status = ST_FULL;
          for (int i = 2; i < scan_end(); i++) begin
            if (fat[i] == FREE_ENTRY) begin
              fat[i] = END_OF_CHAIN;
              want.answer = 16'(i);
              want.status = ST_OK;
              break;
            end
          end
        end
        KIND_FREE: begin
          c = r.cluster;
          freed = 0;
          // Each step frees one entry, so the walk ends on a revisited link.
          while (c >= 2 && c < CHAIN_LIMIT) begin
            if (c >= TABLE_ENTRIES_DEF || freed >= TABLE_ENTRIES_DEF) begin
              want.status = ST_RANGE;
              break;
            end
            nxt = fat[c];
            fat[c] = FREE_ENTRY;
            freed++;
            c = nxt;
          end
          want.answer = 16'(freed);
        end
        KIND_COUNT: begin
          for (int i = 2; i < scan_end(); i++)
            if (fat[i] == FREE_ENTRY) want.answer++;
        end
        default: want.status = ST_RANGE;
      endcase
      pending.push_back(want);
    endfunction

    function string check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0)
        return $sformatf("result answer=%h status=%0d with no request outstanding",
                         got.answer, got.status);
      want = pending.pop_front();
      if (got.answer !== want.answer || got.status !== want.status)
        return $sformatf("answer %h (expected %h), status %0d (expected %0d)",
                         got.answer, want.answer, got.status, want.status);
      return "";
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIU_W-1:0] cfg_data = '0;

  fat_ledger ledger = new();
  int unsigned span_now = CIU_RESET;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned kind_seen [8];
  int unsigned hold_left = 0;
  bit hold_go = 1'b0;
  bit hold_started = 1'b0;

  fat_cluster_table_manager_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // The receiver either serves a long hold-off or stalls at random.
  always @(posedge clk) begin
    if (hold_go && !hold_started) begin
      hold_started <= 1'b1;
      hold_left <= 250;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    string why;
    if (!rst && out_valid && !out_stall) begin
      why = ledger.check_result(out_data);
      if (why != "") report_mismatch(why);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timed out after %0d cycles with no request or result moving", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic req_t mk(logic [2:0] kind, logic [15:0] cluster, logic [15:0] value);
    req_t r;
    r.kind = kind;
    r.cluster = cluster;
    r.entry_value = value;
    return r;
  endfunction

  // Mostly clusters in the searched range, now and then from 0 to just past it.
  function automatic logic [15:0] pick_cluster();
    int unsigned hi;
    hi = (span_now + 1 > 4095) ? 4095 : span_now + 1;
    if (hi < 2) hi = 2;
    if ($urandom_range(9) == 0) return 16'($urandom_range(hi + 2, 0));
    return 16'($urandom_range(hi, 2));
  endfunction

  function automatic logic [15:0] pick_link();
    int unsigned d;
    d = $urandom_range(99);
    if (d < 45) return pick_cluster();
    if (d < 60) return END_OF_CHAIN;
    if (d < 70) return FREE_ENTRY;
    if (d < 80) return 16'($urandom_range(16'hFFFF, CHAIN_LIMIT));
    if (d < 90) return 16'($urandom_range(CHAIN_LIMIT - 1, TABLE_ENTRIES_DEF));
    return 16'($urandom);
  endfunction

  task automatic push_request(input req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_request(r);
    kind_seen[r.kind]++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (ledger.pending.size() != 0);
  endtask

  task automatic write_span(input int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data <= CIU_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ledger.set_span(CIU_W'(v));
    span_now = v;
  endtask

  task automatic random_phase(input int unsigned n_items, input bit pause_mid,
                              input bit hold_mid);
    int unsigned sent;
    int unsigned k;
    int unsigned roll;
    bit mid_done;
    logic [15:0] tail;
    logic [15:0] hops [$];
    req_t r;
    sent = 0;
    mid_done = 1'b0;
    while (sent < n_items) begin
      if (!mid_done && sent >= n_items / 2) begin
        mid_done = 1'b1;
        if (pause_mid) drain();
        if (hold_mid) hold_go <= 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 20) begin
        // Link a few clusters into a chain, then free it from its head.
        k = $urandom_range(5, 2);
        hops.delete();
        repeat (k) hops.push_back(pick_cluster());
        tail = ($urandom_range(3) == 0) ? pick_link() : END_OF_CHAIN;
        for (int i = 0; i < k; i++)
          push_request(mk(KIND_WRITE, hops[i], (i == k - 1) ? tail : hops[i + 1]));
        push_request(mk(KIND_FREE, hops[0], 16'($urandom)));
        sent += k + 1;
      end else begin
        r = mk(KIND_READ, pick_cluster(), 16'($urandom));
        if (roll < 28) begin
          r.kind = 3'($urandom);
          r.cluster = 16'($urandom);
        end else if (roll < 50) begin
          r.kind = KIND_WRITE;
          r.entry_value = pick_link();
        end else if (roll < 64) begin
          r.kind = KIND_READ;
        end else if (roll < 76) begin
          r.kind = KIND_ALLOC;
          r.cluster = 16'($urandom);
        end else if (roll < 90) begin
          r.kind = KIND_FREE;
        end else begin
          r.kind = KIND_COUNT;
          r.cluster = 16'($urandom);
        end
        push_request(r);
        sent++;
      end
    end
  endtask

  initial begin
    src_idle_pct = 6;
    sink_stall_pct = 63;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    write_span(CIU_RESET);
    push_request(mk(KIND_READ, 16'd0, 16'h0000));
    push_request(mk(KIND_WRITE, 16'd0, CHAIN_LIMIT));
    push_request(mk(KIND_WRITE, 16'd1, 16'hFFFF));
    push_request(mk(KIND_READ, 16'd0, 16'hFFFF));
    push_request(mk(KIND_READ, 16'd1, 16'h0000));
    push_request(mk(KIND_WRITE, 16'd4095, 16'hABCD));
    push_request(mk(KIND_READ, 16'd4095, 16'h0000));
    push_request(mk(KIND_READ, 16'd4096, 16'h0000));
    push_request(mk(KIND_WRITE, 16'hFFFF, 16'h1234));
    push_request(mk(KIND_READ, 16'hFFFF, 16'hFFFF));
    push_request(mk(KIND_ALLOC, 16'h0000, 16'h0000));
    push_request(mk(KIND_ALLOC, 16'hFFFF, 16'hFFFF));
    // A chain that reaches the last entry, whose value points past the table.
    push_request(mk(KIND_WRITE, 16'd2, 16'd3));
    push_request(mk(KIND_WRITE, 16'd3, 16'd4095));
    push_request(mk(KIND_FREE, 16'd2, 16'h0000));
    push_request(mk(KIND_FREE, 16'd0, 16'h0000));
    push_request(mk(KIND_FREE, 16'd1, 16'h0000));
    push_request(mk(KIND_FREE, CHAIN_LIMIT, 16'h0000));
    push_request(mk(KIND_FREE, 16'd4096, 16'h0000));
    push_request(mk(KIND_COUNT, 16'h0000, 16'h0000));
    push_request(mk(3'd5, 16'd2, 16'h0000));
    push_request(mk(3'd7, 16'd3, 16'hFFFF));
    drain();
    write_span(0);
    push_request(mk(KIND_ALLOC, 16'h0000, 16'h0000));
    drain();
    write_span(2);
    repeat (3) push_request(mk(KIND_ALLOC, 16'h0000, 16'h0000));
    drain();

    write_span($urandom_range(40, 8));
    random_phase(34, 1'b0, 1'b0);

    drain();
    src_idle_pct = 63;
    sink_stall_pct = 6;
    write_span($urandom_range(64, 0));
    random_phase(34, 1'b1, 1'b0);

    drain();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_span($urandom_range(60, 20));
    random_phase(34, 1'b0, 1'b1);

    // A few requests over the whole table, where scans are at their longest.
    drain();
    write_span(CIU_RESET);
    random_phase(8, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d reads, %0d writes, %0d allocations, %0d chain frees, "
             , kind_seen[KIND_READ], kind_seen[KIND_WRITE], kind_seen[KIND_ALLOC],
             kind_seen[KIND_FREE]);
    $display("%0d free counts and %0d unknown kinds, with table sizes from 0 to %0d clusters.",
             kind_seen[KIND_COUNT], kind_seen[5] + kind_seen[6] + kind_seen[7], CIU_RESET);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
